FILE: hdl/snow2_pkg.sv
// shared types, constants and functions for the snow 2.0 keystream generator
package snow2_pkg;

	localparam int unsigned CFG_COUNT = 7;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IV01 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_IV23 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG = 3'd6;

	localparam logic OP_INIT = 1'b0;
	localparam logic OP_DATA = 1'b1;

	localparam int unsigned INIT_CLOCKS = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MIX,
		ST_FILL,
		ST_XOR,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clock_fb;
		logic clock_ks;
		logic xor_byte;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_fill;
	} dp_stat_t;

	// multiply by x in GF(2^8) with reduction poly
	function automatic logic [7:0] xtime(input logic [7:0] a, input logic [7:0] poly);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? poly : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		logic [7:0] x;
		r = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r = r ^ x;
			x = xtime(x, 8'h1b);
		end
		gf_mul = r;
	endfunction

	// c * beta^k, folded at elaboration when used to fill tables
	function automatic logic [7:0] beta_mul(input logic [7:0] c, input int k);
		logic [7:0] v;
		v = c;
		for (int i = 0; i < k; i++) v = xtime(v, 8'ha9);
		beta_mul = v;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
		rotl8 = (x << n) | (x >> (8 - n));
	endfunction

	function automatic logic [7:0] sbox_calc(input logic [7:0] a);
		logic [7:0] r;
		logic [7:0] b;
		r = 8'h01;
		b = a;
		for (int e = 0; e < 8; e++) begin
			if (e != 0) r = gf_mul(r, b);
			b = gf_mul(b, b);
		end
		sbox_calc = r ^ rotl8(r, 1) ^ rotl8(r, 2) ^ rotl8(r, 3) ^ rotl8(r, 4) ^ 8'h63;
	endfunction

	typedef logic [7:0] byte_tab_t [256];
	typedef logic [31:0] word_tab_t [256];

	function automatic byte_tab_t make_sbox();
		byte_tab_t t;
		for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
		return t;
	endfunction

	function automatic word_tab_t make_alpha();
		word_tab_t t;
		for (int i = 0; i < 256; i++)
			t[i] = {beta_mul(8'(i), 23), beta_mul(8'(i), 245),
				beta_mul(8'(i), 48), beta_mul(8'(i), 239)};
		return t;
	endfunction

	function automatic word_tab_t make_alpha_inv();
		word_tab_t t;
		for (int i = 0; i < 256; i++)
			t[i] = {beta_mul(8'(i), 16), beta_mul(8'(i), 39),
				beta_mul(8'(i), 6), beta_mul(8'(i), 64)};
		return t;
	endfunction

	localparam byte_tab_t SBOX = make_sbox();
	localparam word_tab_t ALPHA_T = make_alpha();
	localparam word_tab_t ALPHA_INV_T = make_alpha_inv();

	function automatic logic [31:0] s_transform(input logic [31:0] w);
		logic [7:0] s0, s1, s2, s3, d0, d1, d2, d3;
		s0 = SBOX[w[7:0]];
		s1 = SBOX[w[15:8]];
		s2 = SBOX[w[23:16]];
		s3 = SBOX[w[31:24]];
		d0 = xtime(s0, 8'h1b);
		d1 = xtime(s1, 8'h1b);
		d2 = xtime(s2, 8'h1b);
		d3 = xtime(s3, 8'h1b);
		s_transform = {d0 ^ s0 ^ s1 ^ s2 ^ d3, s0 ^ s1 ^ d2 ^ d3 ^ s3,
			s0 ^ d1 ^ d2 ^ s2 ^ s3, d0 ^ d1 ^ s1 ^ s2 ^ s3};
	endfunction

endpackage

FILE: hdl/snow2_if.sv
// valid/ready stream interface carrying an input or result payload
interface snow2_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [7:0] data_byte;
	modport source(output valid, output opcode, output data_byte, input ready);
	modport sink(input valid, input opcode, input data_byte, output ready);
endinterface

interface snow2_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic was_init;
	modport source(output valid, output out_byte, output was_init, input ready);
	modport sink(input valid, input out_byte, input was_init, output ready);
endinterface

FILE: hdl/snow2_datapath.sv
// lfsr, fsm registers, keystream buffer and byte xor
module snow2_datapath
	import snow2_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  logic [4*64-1:0]       key,
	input  logic [63:0]           iv01,
	input  logic [63:0]           iv23,
	input  logic                  long_key,
	input  logic [7:0]            data_byte,
	output logic [7:0]            ks_xor
);
	localparam int unsigned BUF_WORDS = (BUFFER_BYTES + 3) / 4;
	localparam int unsigned WIDX_W = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1;
	localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);

	logic [31:0] lfsr_q [16];
	logic [31:0] r1_q, r2_q;
	logic [31:0] buf_q [BUF_WORDS];
	logic [CNT_W-1:0] left_q;
	logic [WIDX_W-1:0] wr_idx_q;
	logic [7:0] ks_xor_q;

	logic [31:0] f_w, nw, nw_fb, r1_n, ks_n;
	logic [31:0] k [8];
	logic [31:0] ld_w [16];
	logic [31:0] rd_word;
	logic [CNT_W-1:0] off;

	// key words and the lfsr image loaded from key and iv
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			k[2*i]   = key[i*64+32 +: 32];
			k[2*i+1] = key[i*64 +: 32];
		end
		for (int i = 0; i < 16; i++) ld_w[i] = '0;
		if (long_key) begin
			for (int i = 0; i < 8; i++) begin
				ld_w[15-i] = k[i];
				ld_w[7-i]  = ~k[i];
			end
		end else begin
			for (int i = 0; i < 4; i++) begin
				ld_w[15-i] = k[i];
				ld_w[11-i] = ~k[i];
				ld_w[7-i]  = k[i];
				ld_w[3-i]  = ~k[i];
			end
		end
		ld_w[15] = ld_w[15] ^ iv01[31:0];
		ld_w[12] = ld_w[12] ^ iv01[63:32];
		ld_w[10] = ld_w[10] ^ iv23[31:0];
		ld_w[9]  = ld_w[9] ^ iv23[63:32];
	end

	// one clocking
	assign f_w   = (r1_q + lfsr_q[15]) ^ r2_q;
	assign nw    = {lfsr_q[0][23:0], 8'h00} ^ ALPHA_T[lfsr_q[0][31:24]] ^ lfsr_q[2] ^
		({8'h00, lfsr_q[11][31:8]} ^ ALPHA_INV_T[lfsr_q[11][7:0]]);
	assign nw_fb = cmd.clock_fb ? (nw ^ f_w) : nw;
	assign r1_n  = r2_q + lfsr_q[5];
	// keystream word after the clocking: lfsr[1] becomes lfsr[0]
	assign ks_n  = ((r1_n + nw) ^ s_transform(r1_q)) ^ lfsr_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) lfsr_q[i] <= '0;
			r1_q <= '0;
			r2_q <= '0;
			left_q <= '0;
			wr_idx_q <= '0;
		end else if (cmd.load) begin
			for (int i = 0; i < 16; i++) lfsr_q[i] <= ld_w[i];
			r1_q <= '0;
			r2_q <= '0;
			wr_idx_q <= '0;
			left_q <= '0;
		end else if (cmd.clock_fb || cmd.clock_ks) begin
			for (int i = 0; i < 15; i++) lfsr_q[i] <= lfsr_q[i+1];
			lfsr_q[15] <= nw_fb;
			r2_q <= s_transform(r1_q);
			r1_q <= r1_n;
			if (cmd.clock_ks) begin
				if (wr_idx_q == WIDX_W'(BUF_WORDS - 1)) begin
					wr_idx_q <= '0;
					left_q <= CNT_W'(BUFFER_BYTES);
				end else begin
					wr_idx_q <= wr_idx_q + 1'b1;
				end
			end
		end else if (cmd.xor_byte) begin
			left_q <= left_q - 1'b1;
		end
	end

	// keystream buffer
	always_ff @(posedge clk) begin
		if (cmd.clock_ks) buf_q[wr_idx_q] <= ks_n;
	end

	assign off = CNT_W'(BUFFER_BYTES) - left_q;
	assign rd_word = buf_q[off[CNT_W-1:2] < CNT_W'(BUF_WORDS) ?
		WIDX_W'(off[CNT_W-1:2]) : '0];

	always_ff @(posedge clk) begin
		if (cmd.xor_byte) ks_xor_q <= data_byte ^ rd_word[off[1:0]*8 +: 8];
	end

	assign stat.need_fill = (left_q == '0);
	assign ks_xor = ks_xor_q;
endmodule

FILE: hdl/snow2_ctrl.sv
// sequencer for initialize, refill and byte requests
module snow2_ctrl
	import snow2_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      opcode,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      was_init,
	output dp_cmd_t   cmd,
	input  dp_stat_t  stat
);
	localparam int unsigned BUF_WORDS = (BUFFER_BYTES + 3) / 4;
	localparam int unsigned CNT_W = $clog2(INIT_CLOCKS + 1);

	state_t state_q, state_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic init_q, init_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			init_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q <= cnt_n;
			init_q <= init_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n = state_q;
		cnt_n = cnt_q;
		init_n = init_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == OP_INIT) begin
						init_n = 1'b1;
						state_n = ST_LOAD;
					end else begin
						init_n = 1'b0;
						cnt_n = '0;
						state_n = stat.need_fill ? ST_FILL : ST_XOR;
					end
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				cnt_n = '0;
				state_n = ST_MIX;
			end
			ST_MIX: begin
				cmd.clock_fb = 1'b1;
				cnt_n = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(INIT_CLOCKS - 1)) begin
					cnt_n = '0;
					state_n = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.clock_ks = 1'b1;
				cnt_n = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(BUF_WORDS - 1)) begin
					cnt_n = '0;
					state_n = init_q ? ST_DONE : ST_XOR;
				end
			end
			ST_XOR: begin
				cmd.xor_byte = 1'b1;
				state_n = ST_DONE;
			end
			ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign was_init = init_q;
endmodule

FILE: hdl/snow2_stream_cipher_top.sv
// top level of the snow 2.0 byte keystream cipher
// data byte: a buffer refill first when the buffer is empty, then the byte xor, then the result
// initialize: load, mixing clockings with the fsm output fed back, buffer fill
// requests: one at a time, the next taken only after the result is accepted; a refill every BUFFER_BYTES
// bytes; one at a time because of the single shared clocking unit and the output holding one result
// arst_n clears lfsr, fsm registers, byte count and config; the buffer is not cleared
module snow2_stream_cipher_top
	import snow2_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	snow2_in_if.sink              in_ch,
	snow2_out_if.source           out_ch
);
	logic [4*64-1:0] key_q;
	logic [63:0] iv01_q, iv23_q;
	logic long_q;
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [7:0] ks_xor;
	logic was_init;
	logic [7:0] data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			iv01_q <= '0;
			iv23_q <= '0;
			long_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY0: key_q[0*64 +: 64] <= cfg_data;
				CFG_KEY1: key_q[1*64 +: 64] <= cfg_data;
				CFG_KEY2: key_q[2*64 +: 64] <= cfg_data;
				CFG_KEY3: key_q[3*64 +: 64] <= cfg_data;
				CFG_IV01: iv01_q <= cfg_data;
				CFG_IV23: iv23_q <= cfg_data;
				CFG_LONG: long_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// capture request byte
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) data_q <= in_ch.data_byte;
	end

	snow2_ctrl #(.BUFFER_BYTES(BUFFER_BYTES)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .opcode(in_ch.opcode),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .was_init(was_init),
		.cmd(cmd), .stat(stat)
	);

	snow2_datapath #(.BUFFER_BYTES(BUFFER_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.key(key_q), .iv01(iv01_q), .iv23(iv23_q), .long_key(long_q),
		.data_byte(data_q), .ks_xor(ks_xor)
	);

	assign out_ch.out_byte = was_init ? 8'h00 : ks_xor;
	assign out_ch.was_init = was_init;
endmodule

FILE: hdl/snow2_checker.sv
// port-level checks for the cipher top, bound to it
module snow2_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       was_init
);
	a_init_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_init |-> out_byte == 8'h00) else $error("init result not zero");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("request taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)) else $error("result dropped");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind snow2_stream_cipher_top snow2_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_byte(out_ch.out_byte), .was_init(out_ch.was_init)
);

FILE: sim/tb.sv
// self-checking testbench for the snow 2.0 byte keystream cipher
`timescale 1ns / 1ps

module tb;
	import snow2_pkg::*;

	localparam int unsigned KS_BYTES = 64;
	localparam int unsigned KS_WORDS = (KS_BYTES + 3) / 4;
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned STALL_LIMIT = 5000;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       was_init;
	} cipher_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	snow2_in_if in_ch();
	snow2_out_if out_ch();

	snow2_stream_cipher_top #(.BUFFER_BYTES(KS_BYTES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// shadow cipher state and register copies
	logic [31:0] shadow_lfsr [16];
	logic [31:0] shadow_r1;
	logic [31:0] shadow_r2;
	logic [31:0] shadow_ks [16];
	int unsigned shadow_left;
	logic [63:0] shadow_key [4];
	logic [63:0] shadow_iv01;
	logic [63:0] shadow_iv23;
	logic shadow_long;

	cipher_result_t expected_results[$];
	int unsigned fails;
	int unsigned quiet_cycles;
	bit no_idle;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// multiply in GF(2^8) with the aes polynomial
	function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		logic [7:0] x;
		r = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r ^= x;
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
		end
		return r;
	endfunction

	function automatic logic [7:0] rot8(input logic [7:0] x, input int n);
		return (x << n) | (x >> (8 - n));
	endfunction

	// aes s-box from inverse and affine map
	function automatic logic [7:0] aes_sub(input logic [7:0] a);
		logic [7:0] r;
		logic [7:0] b;
		int e;
		r = 8'h01;
		b = a;
		e = 254;
		while (e != 0) begin
			if (e & 1) r = gf_mult(r, b);
			b = gf_mult(b, b);
			e >>= 1;
		end
		return r ^ rot8(r, 1) ^ rot8(r, 2) ^ rot8(r, 3) ^ rot8(r, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] beta_pow(input logic [7:0] c, input int k);
		logic [7:0] v;
		v = c;
		for (int i = 0; i < k; i++) v = {v[6:0], 1'b0} ^ (v[7] ? 8'ha9 : 8'h00);
		return v;
	endfunction

	function automatic logic [31:0] alpha_mul(input logic [31:0] w);
		logic [7:0] c;
		c = w[31:24];
		return (w << 8) ^ {beta_pow(c, 23), beta_pow(c, 245), beta_pow(c, 48),
			beta_pow(c, 239)};
	endfunction

	function automatic logic [31:0] alpha_div(input logic [31:0] w);
		logic [7:0] c;
		c = w[7:0];
		return (w >> 8) ^ {beta_pow(c, 16), beta_pow(c, 39), beta_pow(c, 6),
			beta_pow(c, 64)};
	endfunction

	// byte substitution then mix column, byte 0 least significant
	function automatic logic [31:0] sub_mix(input logic [31:0] w);
		logic [7:0] s0, s1, s2, s3, d0, d1, d2, d3;
		s0 = aes_sub(w[7:0]);
		s1 = aes_sub(w[15:8]);
		s2 = aes_sub(w[23:16]);
		s3 = aes_sub(w[31:24]);
		d0 = gf_mult(s0, 8'h02);
		d1 = gf_mult(s1, 8'h02);
		d2 = gf_mult(s2, 8'h02);
		d3 = gf_mult(s3, 8'h02);
		return {d0 ^ s0 ^ s1 ^ s2 ^ d3, s0 ^ s1 ^ d2 ^ d3 ^ s3,
			s0 ^ d1 ^ d2 ^ s2 ^ s3, d0 ^ d1 ^ s1 ^ s2 ^ s3};
	endfunction

	// one lfsr/fsm clocking, fsm output fed back during mixing
	task automatic lfsr_clock(input bit feedback);
		logic [31:0] f, nw, t;
		f = (shadow_r1 + shadow_lfsr[15]) ^ shadow_r2;
		nw = alpha_mul(shadow_lfsr[0]) ^ shadow_lfsr[2] ^ alpha_div(shadow_lfsr[11]);
		t = shadow_r2 + shadow_lfsr[5];
		if (feedback) nw ^= f;
		shadow_r2 = sub_mix(shadow_r1);
		shadow_r1 = t;
		for (int i = 0; i < 15; i++) shadow_lfsr[i] = shadow_lfsr[i + 1];
		shadow_lfsr[15] = nw;
	endtask

	task automatic fill_keystream();
		for (int i = 0; i < KS_WORDS && i < 16; i++) begin
			lfsr_clock(1'b0);
			shadow_ks[i] = ((shadow_r1 + shadow_lfsr[15]) ^ shadow_r2) ^ shadow_lfsr[0];
		end
		shadow_left = KS_BYTES;
	endtask

	task automatic load_key_iv();
		logic [31:0] k [8];
		for (int i = 0; i < 4; i++) begin
			k[2 * i] = shadow_key[i][63:32];
			k[2 * i + 1] = shadow_key[i][31:0];
		end
		if (shadow_long) begin
			for (int i = 0; i < 8; i++) begin
				shadow_lfsr[15 - i] = k[i];
				shadow_lfsr[7 - i] = ~k[i];
			end
		end else begin
			for (int i = 0; i < 4; i++) begin
				shadow_lfsr[15 - i] = k[i];
				shadow_lfsr[11 - i] = ~k[i];
				shadow_lfsr[7 - i] = k[i];
				shadow_lfsr[3 - i] = ~k[i];
			end
		end
		shadow_lfsr[15] ^= shadow_iv01[31:0];
		shadow_lfsr[12] ^= shadow_iv01[63:32];
		shadow_lfsr[10] ^= shadow_iv23[31:0];
		shadow_lfsr[9] ^= shadow_iv23[63:32];
		shadow_r1 = '0;
		shadow_r2 = '0;
		for (int i = 0; i < INIT_CLOCKS; i++) lfsr_clock(1'b1);
		fill_keystream();
	endtask

	// expected result of one accepted request
	task automatic predict_cipher(input logic op, input logic [7:0] data);
		cipher_result_t res;
		int unsigned off;
		logic [7:0] ks;
		if (op == OP_INIT) begin
			load_key_iv();
			res.out_byte = 8'h00;
			res.was_init = 1'b1;
		end else begin
			if (shadow_left == 0 || shadow_left > KS_BYTES) fill_keystream();
			off = KS_BYTES - shadow_left;
			shadow_left--;
			ks = 8'(shadow_ks[(off >> 2) & 15] >> ((off & 3) * 8));
			res.out_byte = data ^ ks;
			res.was_init = 1'b0;
		end
		expected_results.push_back(res);
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	function automatic int unsigned draw_gap();
		return no_idle ? 0 : $urandom_range(0, 15);
	endfunction

	// register write, called at a falling edge with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_KEY0: shadow_key[0] = val;
			CFG_KEY1: shadow_key[1] = val;
			CFG_KEY2: shadow_key[2] = val;
			CFG_KEY3: shadow_key[3] = val;
			CFG_IV01: shadow_iv01 = val;
			CFG_IV23: shadow_iv23 = val;
			CFG_LONG: shadow_long = val[0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [63:0] k0, input logic [63:0] k1,
		input logic [63:0] k2, input logic [63:0] k3, input logic [63:0] iv01,
		input logic [63:0] iv23, input logic [63:0] lng);
		write_reg(CFG_KEY0, k0);
		write_reg(CFG_KEY1, k1);
		write_reg(CFG_KEY2, k2);
		write_reg(CFG_KEY3, k3);
		write_reg(CFG_IV01, iv01);
		write_reg(CFG_IV23, iv23);
		write_reg(CFG_LONG, lng);
	endtask

	// send one request; returns at the falling edge after acceptance, valid still high
	task automatic send_request(input logic op, input logic [7:0] data);
		int unsigned gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.data_byte <= data;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		predict_cipher(op, data);
		@(negedge clk);
	endtask

	// drain: sender holds off until every result is back and the block has settled
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic test_before_init();
		for (int i = 0; i < 6; i++) send_request(OP_DATA, 8'($urandom));
		drain();
	endtask

	task automatic test_directed();
		write_all('0, '0, '0, '0, '0, '0, 64'd0);
		send_request(OP_INIT, 8'hff);
		send_request(OP_DATA, 8'h00);
		send_request(OP_DATA, 8'hff);
		send_request(OP_DATA, 8'haa);
		send_request(OP_DATA, 8'h55);
		drain();
		write_all('1, '1, '1, '1, '1, '1, '1);
		send_request(OP_INIT, 8'h00);
		// two initializes back to back, then a partly used buffer re-initialized
		send_request(OP_INIT, 8'h5a);
		for (int i = 0; i < 5; i++) send_request(OP_DATA, 8'($urandom));
		send_request(OP_INIT, 8'h00);
		send_request(OP_DATA, 8'hff);
		drain();
	endtask

	// crosses two buffer refills under one setting
	task automatic test_refill();
		write_all({$urandom, $urandom}, {$urandom, $urandom}, '0, '0,
			{$urandom, $urandom}, {$urandom, $urandom}, 64'd0);
		send_request(OP_INIT, 8'h00);
		for (int i = 0; i < 140; i++) send_request(OP_DATA, 8'($urandom));
		drain();
	endtask

	task automatic test_random(input int unsigned phases, input int unsigned per_phase);
		logic op;
		for (int p = 0; p < phases; p++) begin
			no_idle = (p == 1);
			write_all({$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
			send_request(OP_INIT, 8'($urandom));
			for (int i = 0; i < per_phase; i++) begin
				op = ($urandom_range(0, 19) == 0) ? OP_INIT : OP_DATA;
				send_request(op, 8'($urandom));
			end
			drain();
		end
		no_idle = 1'b0;
	endtask

	// result side: random stalls, check each result against the oldest expectation
	initial begin
		int unsigned gap;
		cipher_result_t want;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = draw_gap();
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", out_ch.out_byte, 8'h00);
			end else begin
				want = expected_results.pop_front();
				if (out_ch.out_byte !== want.out_byte)
					report_mismatch("out_byte", out_ch.out_byte, want.out_byte);
				if (out_ch.was_init !== want.was_init)
					report_mismatch("was_init", 8'(out_ch.was_init), 8'(want.was_init));
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		fails = 0;
		quiet_cycles = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_DATA;
		in_ch.data_byte = '0;
		for (int i = 0; i < 16; i++) begin
			shadow_lfsr[i] = '0;
			shadow_ks[i] = '0;
		end
		for (int i = 0; i < 4; i++) shadow_key[i] = '0;
		shadow_r1 = '0;
		shadow_r2 = '0;
		shadow_left = 0;
		shadow_iv01 = '0;
		shadow_iv23 = '0;
		shadow_long = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_before_init();
		test_directed();
		test_refill();
		test_random(6, 200);
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
